>>> src/pspf_pkg.sv
// Shared types, codes and constants of the power stage fault protector.
// Used by pspf_fault_merge and power_stage_fault_protector_core.
// No dependencies.
package pspf_pkg;

  // Configurable sizing
  localparam int PHASES          = 4;
  localparam int PHASE_FIELDS    = 4;
  localparam int LANES           = (PHASES < PHASE_FIELDS) ? PHASES : PHASE_FIELDS;
  localparam int OCP_HOLD_US     = 1000;
  localparam int VOUT_NOMINAL_MV = 12000;
  localparam int SOFTSTART_MARGIN_MV = 300;

  // Hold timer width: holds 0..OCP_HOLD_US
  localparam int TMR_W = $clog2(OCP_HOLD_US + 1);
  // Width of timer plus elapsed step without overflow
  localparam int SUM_W = ((TMR_W > 16) ? TMR_W : 16) + 1;

  localparam logic [TMR_W-1:0] HOLD_TMR = TMR_W'(OCP_HOLD_US);
  localparam logic [SUM_W-1:0] HOLD_SUM = SUM_W'(OCP_HOLD_US);
  localparam logic [15:0] SOFTSTART_MV = 16'(VOUT_NOMINAL_MV - SOFTSTART_MARGIN_MV);

  // Port widths
  localparam int IN_DATA_W  = 152;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 18;

  // Item operation codes
  typedef enum logic [1:0] {
    OP_EVAL  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_BRAKE = 2'd2
  } op_t;

  // Fault codes
  typedef enum logic [3:0] {
    FLT_OK        = 4'd0,
    FLT_PHASE_OCP = 4'd1,
    FLT_OUT_OCP   = 4'd2,
    FLT_SHORT     = 4'd3,
    FLT_OVP       = 4'd4,
    FLT_VIN_OVER  = 4'd5,
    FLT_VIN_UNDER = 4'd6,
    FLT_OVERTEMP  = 4'd7,
    FLT_HW_BRAKE  = 4'd8
  } fault_t;

  // Sequencer state, one-hot
  typedef enum logic [3:0] {
    SEQ_IDLE  = 4'b0001,
    SEQ_SOFT  = 4'b0010,
    SEQ_RUN   = 4'b0100,
    SEQ_FAULT = 4'b1000
  } seq_t;

  // Reported run phase codes
  localparam logic [1:0] RUN_IDLE  = 2'd0;
  localparam logic [1:0] RUN_SOFT  = 2'd1;
  localparam logic [1:0] RUN_RUN   = 2'd2;
  localparam logic [1:0] RUN_FAULT = 2'd3;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_OVP        = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_VIN_OVER   = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_VIN_UNDER  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_OVER_TEMP  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_SHORT_VOUT = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_SHORT_IOUT = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_OVER = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_OUT_OVER   = 3'd7;

  // Input word, last field (vout_mv) in the lowest bits
  typedef struct packed {
    logic [3:0]         pad;
    logic [15:0]        elapsed_us;
    logic signed [17:0] phase3_current_ma;
    logic signed [17:0] phase2_current_ma;
    logic signed [17:0] phase1_current_ma;
    logic signed [17:0] phase0_current_ma;
    logic signed [18:0] iout_ma;
    logic signed [8:0]  temp_c;
    logic [15:0]        vin_mv;
    logic [15:0]        vout_mv;
  } in_word_t;

  typedef struct packed {
    logic [15:0]        ovp_limit_mv;
    logic [15:0]        vin_over_limit_mv;
    logic [15:0]        vin_under_limit_mv;
    logic signed [8:0]  over_temp_limit_c;
    logic [15:0]        short_vout_limit_mv;
    logic [17:0]        short_iout_limit_ma;
    logic [16:0]        phase_over_limit_ma;
    logic [17:0]        out_over_limit_ma;
  } cfg_t;

  typedef struct packed {
    logic [1:0] run_phase;
    logic [3:0] fault_code;
  } result_t;

  function automatic logic [1:0] seq_to_phase(seq_t s);
    logic [1:0] p;
    case (s)
      SEQ_IDLE:  p = RUN_IDLE;
      SEQ_SOFT:  p = RUN_SOFT;
      SEQ_RUN:   p = RUN_RUN;
      SEQ_FAULT: p = RUN_FAULT;
      default:   p = RUN_IDLE;
    endcase
    return p;
  endfunction

endpackage

>>> src/pspf_phase_lane.sv
// One phase overcurrent lane: compares a signed phase current to its limit.
// Depends on no other file.
module pspf_phase_lane (
  input  logic signed [17:0] phase_ma,
  input  logic [16:0]        limit_ma,
  output logic               trip
);

  // Zero-extend the unsigned limit into the signed domain
  assign trip = phase_ma > $signed({1'b0, limit_ma});

endmodule

>>> src/pspf_fault_merge.sv
// Fault priority merge, output overcurrent hold timer and run sequencer.
// Depends on pspf_pkg; takes the phase lane trips from pspf_phase_lane.
module pspf_fault_merge (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          accept,
  input  logic [1:0]                    operation,
  input  pspf_pkg::in_word_t            word,
  input  pspf_pkg::cfg_t                cfg,
  input  logic [pspf_pkg::LANES-1:0]    lane_trip,
  output pspf_pkg::result_t             result
);

  pspf_pkg::seq_t                   seq_r, seq_nxt;
  pspf_pkg::fault_t                 stored_r, stored_nxt;
  logic                             brake_r, brake_nxt;
  logic [pspf_pkg::TMR_W-1:0]       tmr_r, tmr_nxt;

  pspf_pkg::fault_t                 picked;
  pspf_pkg::fault_t                 code;
  logic                             oc_over;
  logic [pspf_pkg::SUM_W-1:0]       tmr_sum;
  logic [pspf_pkg::SUM_W-1:0]       tmr_sat;

  // Fixed priority pick of the instantaneous faults
  always_comb begin
    if (word.vout_mv >= cfg.ovp_limit_mv) begin
      picked = pspf_pkg::FLT_OVP;
    end else if (word.vin_mv >= cfg.vin_over_limit_mv) begin
      picked = pspf_pkg::FLT_VIN_OVER;
    end else if (word.vin_mv != 16'd0 && word.vin_mv < cfg.vin_under_limit_mv) begin
      picked = pspf_pkg::FLT_VIN_UNDER;
    end else if (word.temp_c >= cfg.over_temp_limit_c) begin
      picked = pspf_pkg::FLT_OVERTEMP;
    end else if (word.vout_mv < cfg.short_vout_limit_mv &&
                 word.iout_ma > $signed({1'b0, cfg.short_iout_limit_ma})) begin
      picked = pspf_pkg::FLT_SHORT;
    end else if (|lane_trip) begin
      picked = pspf_pkg::FLT_PHASE_OCP;
    end else begin
      picked = pspf_pkg::FLT_OK;
    end
  end

  // Hold timer: accumulate while over the output limit, saturate at hold time
  assign oc_over = word.iout_ma > $signed({1'b0, cfg.out_over_limit_ma});
  assign tmr_sum = pspf_pkg::SUM_W'(tmr_r) + pspf_pkg::SUM_W'(word.elapsed_us);
  assign tmr_sat = (tmr_sum > pspf_pkg::HOLD_SUM) ? pspf_pkg::HOLD_SUM : tmr_sum;

  // Timed overcurrent overrides whatever else was picked
  assign code = (oc_over && tmr_sat >= pspf_pkg::HOLD_SUM) ? pspf_pkg::FLT_OUT_OCP : picked;

  always_comb begin
    seq_nxt    = seq_r;
    stored_nxt = stored_r;
    brake_nxt  = brake_r;
    tmr_nxt    = tmr_r;
    case (operation)
      pspf_pkg::OP_EVAL: begin
        if (seq_r == pspf_pkg::SEQ_FAULT) begin
          seq_nxt = pspf_pkg::SEQ_FAULT;
        end else if (brake_r) begin
          stored_nxt = pspf_pkg::FLT_HW_BRAKE;
          seq_nxt    = pspf_pkg::SEQ_FAULT;
        end else begin
          tmr_nxt = oc_over ? tmr_sat[pspf_pkg::TMR_W-1:0] : '0;
          if (code != pspf_pkg::FLT_OK) begin
            stored_nxt = code;
            seq_nxt    = pspf_pkg::SEQ_FAULT;
          end else if (seq_r == pspf_pkg::SEQ_IDLE) begin
            seq_nxt = pspf_pkg::SEQ_SOFT;
          end else if (seq_r == pspf_pkg::SEQ_SOFT &&
                       word.vout_mv >= pspf_pkg::SOFTSTART_MV) begin
            seq_nxt = pspf_pkg::SEQ_RUN;
          end
        end
      end
      pspf_pkg::OP_CLEAR: begin
        // a short circuit stays latched
        if (stored_r != pspf_pkg::FLT_SHORT) begin
          seq_nxt    = pspf_pkg::SEQ_IDLE;
          stored_nxt = pspf_pkg::FLT_OK;
          brake_nxt  = 1'b0;
          tmr_nxt    = '0;
        end
      end
      pspf_pkg::OP_BRAKE: begin
        brake_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // The reported code is always the stored fault after the item
  assign result.fault_code = stored_nxt;
  assign result.run_phase  = pspf_pkg::seq_to_phase(seq_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r    <= pspf_pkg::SEQ_IDLE;
      stored_r <= pspf_pkg::FLT_OK;
      brake_r  <= 1'b0;
      tmr_r    <= '0;
    end else if (accept) begin
      seq_r    <= seq_nxt;
      stored_r <= stored_nxt;
      brake_r  <= brake_nxt;
      tmr_r    <= tmr_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_fault_state_matches: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == pspf_pkg::SEQ_FAULT) == (stored_r != pspf_pkg::FLT_OK))
    else $error("sequencer fault state and stored fault disagree");

  a_timer_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    tmr_r <= pspf_pkg::HOLD_TMR)
    else $error("hold timer above hold time");

  a_short_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stored_r == pspf_pkg::FLT_SHORT |=> stored_r == pspf_pkg::FLT_SHORT)
    else $error("short circuit fault released");

  a_idle_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(seq_r) && $stable(stored_r) && $stable(tmr_r))
    else $error("state moved without an accepted word");
`endif

endmodule

>>> src/power_stage_fault_protector_core.sv
// Power stage fault protector, top level: config registers, phase lanes,
// fault merge and a two-entry output buffer. Depends on pspf_pkg,
// pspf_phase_lane and pspf_fault_merge.
//
// Fault supervisor for a multiphase buck stage. Each input word is one item:
// evaluate (tuser 0), clear (1) or hardware brake (2); every word yields exactly
// one result word carrying the fault code and run phase after the item. One
// word is taken per clock: the phase overcurrent compares run in parallel
// lanes, one per phase, and a single merge stage picks the fault by priority
// and updates the sequencer in the accept cycle. The result is registered in the
// output register, or in the skid entry while that one is full. The two entries let
// the input keep taking words while a result waits; in_tready drops only when
// both entries are full. Configuration writes land at the next clock edge and
// should be issued only while no results are outstanding.
module power_stage_fault_protector_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // tdata: vout_mv, vin_mv, temp_c, iout_ma, phase0..3_current_ma, elapsed_us, pad
  input  logic [pspf_pkg::IN_DATA_W-1:0]      in_tdata,
  // tuser: operation
  input  logic [pspf_pkg::IN_USER_W-1:0]      in_tuser,
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // tdata: fault_code [3:0], run_phase [5:4], pad
  output logic [pspf_pkg::OUT_DATA_W-1:0]     out_tdata,
  // Configuration write port
  input  logic                                cfg_we,
  input  logic [pspf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pspf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  pspf_pkg::in_word_t               word;
  pspf_pkg::cfg_t                   cfg_r;
  pspf_pkg::result_t                res;
  pspf_pkg::result_t                out_res_r, out_res_nxt;
  pspf_pkg::result_t                skid_res_r, skid_res_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             skid_valid_r, skid_valid_nxt;
  logic                             in_acc;
  logic                             out_take;
  logic signed [17:0]               phase_ma [pspf_pkg::PHASE_FIELDS];
  logic [pspf_pkg::LANES-1:0]       lane_trip;

  assign word = pspf_pkg::in_word_t'(in_tdata);

  assign phase_ma[0] = word.phase0_current_ma;
  assign phase_ma[1] = word.phase1_current_ma;
  assign phase_ma[2] = word.phase2_current_ma;
  assign phase_ma[3] = word.phase3_current_ma;

  // Config registers: write at the edge, no read-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ovp_limit_mv        <= 16'd13500;
      cfg_r.vin_over_limit_mv   <= 16'd60000;
      cfg_r.vin_under_limit_mv  <= 16'd9000;
      cfg_r.over_temp_limit_c   <= 9'sd100;
      cfg_r.short_vout_limit_mv <= 16'd3000;
      cfg_r.short_iout_limit_ma <= 18'd220000;
      cfg_r.phase_over_limit_ma <= 17'd60000;
      cfg_r.out_over_limit_ma   <= 18'd210000;
    end else if (cfg_we) begin
      case (cfg_addr)
        pspf_pkg::REG_OVP:        cfg_r.ovp_limit_mv        <= cfg_wdata[15:0];
        pspf_pkg::REG_VIN_OVER:   cfg_r.vin_over_limit_mv   <= cfg_wdata[15:0];
        pspf_pkg::REG_VIN_UNDER:  cfg_r.vin_under_limit_mv  <= cfg_wdata[15:0];
        pspf_pkg::REG_OVER_TEMP:  cfg_r.over_temp_limit_c   <= $signed(cfg_wdata[8:0]);
        pspf_pkg::REG_SHORT_VOUT: cfg_r.short_vout_limit_mv <= cfg_wdata[15:0];
        pspf_pkg::REG_SHORT_IOUT: cfg_r.short_iout_limit_ma <= cfg_wdata[17:0];
        pspf_pkg::REG_PHASE_OVER: cfg_r.phase_over_limit_ma <= cfg_wdata[16:0];
        pspf_pkg::REG_OUT_OVER:   cfg_r.out_over_limit_ma   <= cfg_wdata[17:0];
        default: begin
        end
      endcase
    end
  end

  // One compare lane per checked phase
  for (genvar g = 0; g < pspf_pkg::LANES; g++) begin : g_lane
    pspf_phase_lane u_lane (
      .phase_ma (phase_ma[g]),
      .limit_ma (cfg_r.phase_over_limit_ma),
      .trip     (lane_trip[g])
    );
  end

  pspf_fault_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_acc),
    .operation (in_tuser),
    .word      (word),
    .cfg       (cfg_r),
    .lane_trip (lane_trip),
    .result    (res)
  );

  // Output register plus skid entry
  assign in_tready = !skid_valid_r;
  assign in_acc    = in_tvalid && in_tready;
  assign out_take  = out_valid_r && out_tready;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (skid_valid_r) begin
      // input is stalled; drain skid into output when taken
      if (out_take) begin
        out_res_nxt    = skid_res_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_valid_r || out_take) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = res;
      end else begin
        skid_valid_nxt = 1'b1;
        skid_res_nxt   = res;
      end
    end else if (out_take) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_res_r};

`ifndef NO_ASSERTIONS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> out_valid_r)
    else $error("accepted word produced no pending result");

  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_take |=> out_valid_r && out_res_r == $past(skid_res_r))
    else $error("skid entry not forwarded in order");
`endif

endmodule

>>> test/pspf_protect_checker.sv
`timescale 1ns / 100ps
// Result checker for power_stage_fault_protector_core: mirrors the limit
// registers, predicts fault code and run phase per accepted word, compares.
// Depends on pspf_pkg only.
module pspf_protect_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [pspf_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [pspf_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [pspf_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [pspf_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [pspf_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              bad_results,
  output int                              results_owed
);

  pspf_pkg::cfg_t    lim;
  logic [1:0]        run_state;
  pspf_pkg::fault_t  held_fault;
  logic              latched;
  logic              brake_armed;
  int unsigned       oc_time_us;
  pspf_pkg::result_t owed_results[$];

  // Instant faults in priority order; the timed output overcurrent is added later.
  function automatic pspf_pkg::fault_t classify(pspf_pkg::in_word_t w);
    int temp_c;
    int temp_lim;
    int iout;
    int amps[4];
    temp_c   = $signed(w.temp_c);
    temp_lim = $signed(lim.over_temp_limit_c);
    iout     = $signed(w.iout_ma);
    amps[0]  = $signed(w.phase0_current_ma);
    amps[1]  = $signed(w.phase1_current_ma);
    amps[2]  = $signed(w.phase2_current_ma);
    amps[3]  = $signed(w.phase3_current_ma);
    if (w.vout_mv >= lim.ovp_limit_mv) return pspf_pkg::FLT_OVP;
    if (w.vin_mv >= lim.vin_over_limit_mv) return pspf_pkg::FLT_VIN_OVER;
    if (w.vin_mv != 16'd0 && w.vin_mv < lim.vin_under_limit_mv)
      return pspf_pkg::FLT_VIN_UNDER;
    if (temp_c >= temp_lim) return pspf_pkg::FLT_OVERTEMP;
    if (w.vout_mv < lim.short_vout_limit_mv && iout > int'(lim.short_iout_limit_ma))
      return pspf_pkg::FLT_SHORT;
    for (int i = 0; i < pspf_pkg::LANES; i++) begin
      if (amps[i] > int'(lim.phase_over_limit_ma)) return pspf_pkg::FLT_PHASE_OCP;
    end
    return pspf_pkg::FLT_OK;
  endfunction

  task automatic clear_protection();
    run_state   = pspf_pkg::RUN_IDLE;
    held_fault  = pspf_pkg::FLT_OK;
    latched     = 1'b0;
    brake_armed = 1'b0;
    oc_time_us  = 0;
  endtask

  task automatic step_protector(input logic [1:0] op, input pspf_pkg::in_word_t w,
                                output pspf_pkg::result_t r);
    pspf_pkg::fault_t code;
    int               iout;
    int unsigned      acc;
    if (op == pspf_pkg::OP_EVAL) begin
      if (latched) begin
        run_state = pspf_pkg::RUN_FAULT;
        code = held_fault;
      end else if (brake_armed) begin
        held_fault = pspf_pkg::FLT_HW_BRAKE;
        latched    = 1'b1;
        run_state  = pspf_pkg::RUN_FAULT;
        code       = pspf_pkg::FLT_HW_BRAKE;
      end else begin
        code = classify(w);
        iout = $signed(w.iout_ma);
        if (iout > int'(lim.out_over_limit_ma)) begin
          // accumulate and saturate; reaching the hold time overrides any other fault
          acc = oc_time_us + w.elapsed_us;
          if (acc > pspf_pkg::OCP_HOLD_US) acc = pspf_pkg::OCP_HOLD_US;
          oc_time_us = acc;
          if (acc >= pspf_pkg::OCP_HOLD_US) code = pspf_pkg::FLT_OUT_OCP;
        end else begin
          oc_time_us = 0;
        end
        if (code != pspf_pkg::FLT_OK) begin
          held_fault = code;
          latched    = 1'b1;
          run_state  = pspf_pkg::RUN_FAULT;
        end else if (run_state == pspf_pkg::RUN_IDLE) begin
          run_state = pspf_pkg::RUN_SOFT;
        end else if (run_state == pspf_pkg::RUN_SOFT &&
                     w.vout_mv >= pspf_pkg::SOFTSTART_MV) begin
          run_state = pspf_pkg::RUN_RUN;
        end
      end
    end else begin
      // a short circuit survives a clear; the spare code changes nothing
      if (op == pspf_pkg::OP_CLEAR) begin
        if (held_fault != pspf_pkg::FLT_SHORT) clear_protection();
      end else if (op == pspf_pkg::OP_BRAKE) begin
        brake_armed = 1'b1;
      end
      code = held_fault;
    end
    r.fault_code = code;
    r.run_phase  = run_state;
  endtask

  task automatic log_mismatch(input string why, input pspf_pkg::result_t want,
                              input pspf_pkg::result_t seen);
    bad_results++;
    if (bad_results <= 10)
      $display("%0t: %s: expected fault %0d phase %0d, got fault %0d phase %0d", $time, why,
               want.fault_code, want.run_phase, seen.fault_code, seen.run_phase);
  endtask

  always @(posedge clk) begin
    pspf_pkg::result_t want;
    pspf_pkg::result_t seen;
    if (!rst_n) begin
      lim.ovp_limit_mv        = 16'd13500;
      lim.vin_over_limit_mv   = 16'd60000;
      lim.vin_under_limit_mv  = 16'd9000;
      lim.over_temp_limit_c   = 9'd100;
      lim.short_vout_limit_mv = 16'd3000;
      lim.short_iout_limit_ma = 18'd220000;
      lim.phase_over_limit_ma = 17'd60000;
      lim.out_over_limit_ma   = 18'd210000;
      clear_protection();
      owed_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          pspf_pkg::REG_OVP:        lim.ovp_limit_mv        = cfg_wdata[15:0];
          pspf_pkg::REG_VIN_OVER:   lim.vin_over_limit_mv   = cfg_wdata[15:0];
          pspf_pkg::REG_VIN_UNDER:  lim.vin_under_limit_mv  = cfg_wdata[15:0];
          pspf_pkg::REG_OVER_TEMP:  lim.over_temp_limit_c   = cfg_wdata[8:0];
          pspf_pkg::REG_SHORT_VOUT: lim.short_vout_limit_mv = cfg_wdata[15:0];
          pspf_pkg::REG_SHORT_IOUT: lim.short_iout_limit_ma = cfg_wdata[17:0];
          pspf_pkg::REG_PHASE_OVER: lim.phase_over_limit_ma = cfg_wdata[16:0];
          pspf_pkg::REG_OUT_OVER:   lim.out_over_limit_ma   = cfg_wdata[17:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        step_protector(in_tuser, pspf_pkg::in_word_t'(in_tdata), want);
        owed_results.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        seen = pspf_pkg::result_t'(out_tdata[5:0]);
        if (owed_results.size() == 0) begin
          log_mismatch("unexpected result", '0, seen);
        end else begin
          want = owed_results.pop_front();
          if (seen.fault_code !== want.fault_code || seen.run_phase !== want.run_phase)
            log_mismatch("result mismatch", want, seen);
        end
      end
    end
    results_owed = owed_results.size();
  end

endmodule

>>> test/tb_power_stage_fault_protector_core.sv
`timescale 1ns / 100ps
// Testbench top for power_stage_fault_protector_core: clock, reset, stimulus,
// limit programming and verdict. Depends on pspf_pkg, the block and pspf_protect_checker.
module tb_power_stage_fault_protector_core;

  // Operation code the block does not define; it must answer like a clear that does nothing.
  localparam logic [1:0] OP_SPARE     = 2'd3;
  localparam int         PHASE_ITEMS  = 125;
  localparam int         SOFT_EDGE_MV = pspf_pkg::VOUT_NOMINAL_MV -
                                        pspf_pkg::SOFTSTART_MARGIN_MV;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic [pspf_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic [pspf_pkg::IN_USER_W-1:0]  in_tuser   = '0;
  logic                            out_tready = 1'b0;
  logic                            cfg_we     = 1'b0;
  logic [pspf_pkg::CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [pspf_pkg::CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                            in_tready;
  logic                            out_tvalid;
  logic [pspf_pkg::OUT_DATA_W-1:0] out_tdata;

  int bad_results;
  int results_owed;

  // Idle percentages per side, changed only between phases.
  int send_gap_pct   = 11;
  int recv_stall_pct = 57;
  // Short circuit is permanent once latched, so keep it out until the closing words.
  bit short_allowed  = 1'b0;

  // Stimulus-side copy of the limits, used to shape healthy measurements.
  int ovp_mv        = 13500;
  int vin_over_mv   = 60000;
  int vin_under_mv  = 9000;
  int temp_lim_c    = 100;
  int short_vout_mv = 3000;
  int short_iout_ma = 220000;
  int phase_lim_ma  = 60000;
  int out_over_ma   = 210000;

  power_stage_fault_protector_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // vout_mv, vin_mv, temp_c, iout_ma, phase0..3, elapsed_us
    .in_tuser   (in_tuser),    // operation
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // fault_code, run_phase
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  pspf_protect_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .bad_results  (bad_results),
    .results_owed (results_owed)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #2000000;
    $display("tb_power_stage_fault_protector_core: FAIL");
    $finish;
  end

  // Receiver: stall at random, decided once per falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Uniform pick in [lo, hi]; collapses to lo when the range is empty.
  function automatic int pick(int lo, int hi);
    if (hi <= lo) return lo;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // Quiet operating point: nothing trips under the reset limits.
  function automatic pspf_pkg::in_word_t calm_word(int vout);
    pspf_pkg::in_word_t w;
    w                   = '0;
    w.vout_mv           = 16'(vout);
    w.vin_mv            = 16'd12000;
    w.temp_c            = 9'sd25;
    w.iout_ma           = 19'sd1000;
    w.phase0_current_ma = 18'sd1000;
    w.phase1_current_ma = 18'sd1000;
    w.phase2_current_ma = 18'sd1000;
    w.phase3_current_ma = 18'sd1000;
    w.elapsed_us        = 16'd10;
    return w;
  endfunction

  // Present one word and hold it until accepted. Enter and leave at a falling edge,
  // leaving valid high so back-to-back words never lower and raise it in one step.
  task automatic send_word(input logic [1:0] op, input pspf_pkg::in_word_t w);
    if (!short_allowed && op == pspf_pkg::OP_EVAL && int'(w.vout_mv) < short_vout_mv
        && int'($signed(w.iout_ma)) > short_iout_ma)
      w.vout_mv = 16'(short_vout_mv);
    while ($urandom_range(99) < send_gap_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Drop valid, wait for every owed result, then leave the block idle before returning.
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (results_owed != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [pspf_pkg::CFG_ADDR_W-1:0] idx, input int value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= (idx == pspf_pkg::REG_OVER_TEMP)
                 ? {{(pspf_pkg::CFG_DATA_W-9){1'b0}}, 9'(value)}
                 : pspf_pkg::CFG_DATA_W'(value);
    case (idx)
      pspf_pkg::REG_OVP:        ovp_mv        = value;
      pspf_pkg::REG_VIN_OVER:   vin_over_mv   = value;
      pspf_pkg::REG_VIN_UNDER:  vin_under_mv  = value;
      pspf_pkg::REG_OVER_TEMP:  temp_lim_c    = value;
      pspf_pkg::REG_SHORT_VOUT: short_vout_mv = value;
      pspf_pkg::REG_SHORT_IOUT: short_iout_ma = value;
      pspf_pkg::REG_PHASE_OVER: phase_lim_ma  = value;
      pspf_pkg::REG_OUT_OVER:   out_over_ma   = value;
      default: ;
    endcase
    @(negedge clk);
  endtask

  // Mostly healthy measurements around the current limits, with one field knocked
  // out of range now and then; the rest is clears, brakes, the spare code and noise.
  task automatic random_item();
    pspf_pkg::in_word_t w;
    logic [159:0]       raw;
    int                 roll;
    int                 amps;
    raw    = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w      = pspf_pkg::in_word_t'(raw[151:0]);
    w.pad  = '0;
    roll   = $urandom_range(99);
    if (roll < 10) begin
      send_word(pspf_pkg::OP_CLEAR, w);
    end else if (roll < 14) begin
      send_word(pspf_pkg::OP_BRAKE, w);
    end else if (roll < 16) begin
      send_word(OP_SPARE, w);
    end else if (roll < 28) begin
      send_word(pspf_pkg::OP_EVAL, w);
    end else begin
      w.vout_mv = 16'(($urandom_range(1) == 1) ? pick(SOFT_EDGE_MV, ovp_mv - 1)
                                               : pick(0, ovp_mv - 1));
      w.vin_mv  = 16'(($urandom_range(9) == 0) ? 0 : pick(vin_under_mv, vin_over_mv - 1));
      w.temp_c  = 9'(pick(-40, temp_lim_c - 1));
      if ($urandom_range(2) == 0) begin
        // push the hold timer
        amps = pick(out_over_ma + 1, out_over_ma + 40000);
        if (amps > 262143) amps = 262143;
      end else begin
        amps = pick(-5000, out_over_ma);
      end
      w.iout_ma           = 19'(amps);
      w.phase0_current_ma = 18'(pick(-20000, phase_lim_ma));
      w.phase1_current_ma = 18'(pick(-20000, phase_lim_ma));
      w.phase2_current_ma = 18'(pick(-20000, phase_lim_ma));
      w.phase3_current_ma = 18'(pick(-20000, phase_lim_ma));
      w.elapsed_us = 16'(($urandom_range(7) == 0) ? $urandom_range(65535)
                                                  : $urandom_range(300));
      if ($urandom_range(4) == 0) begin
        case ($urandom_range(8))
          0: w.vout_mv           = 16'($urandom);
          1: w.vin_mv            = 16'($urandom);
          2: w.temp_c            = 9'($urandom);
          3: w.iout_ma           = 19'($urandom);
          4: w.phase0_current_ma = 18'($urandom);
          5: w.phase1_current_ma = 18'($urandom);
          6: w.phase2_current_ma = 18'($urandom);
          7: w.phase3_current_ma = 18'($urandom);
          default: w.elapsed_us  = 16'($urandom);
        endcase
      end
      send_word(pspf_pkg::OP_EVAL, w);
    end
  endtask

  initial begin
    pspf_pkg::in_word_t w;
    int                 lims[8];
    // Hold reset, then release on a falling edge.
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed words under the reset limits.
    w = calm_word(5000);
    send_word(pspf_pkg::OP_EVAL, w);             // idle to soft start
    w.vout_mv = 16'(SOFT_EDGE_MV - 1);
    send_word(pspf_pkg::OP_EVAL, w);             // one below the soft start edge: stay
    w.vout_mv = 16'(SOFT_EDGE_MV);
    send_word(pspf_pkg::OP_EVAL, w);             // right at the edge: run
    send_word(pspf_pkg::OP_EVAL, calm_word(5000));   // run holds
    send_word(pspf_pkg::OP_EVAL, calm_word(ovp_mv)); // over-voltage right at the limit
    w = '1;
    w.pad = '0;
    send_word(pspf_pkg::OP_EVAL, w);             // latched: measurements ignored
    send_word(OP_SPARE, calm_word(5000));        // spare code reports the stored fault
    send_word(pspf_pkg::OP_CLEAR, calm_word(5000));
    w = calm_word(5000);
    w.vin_mv = 16'(vin_over_mv);
    send_word(pspf_pkg::OP_EVAL, w);             // input over-voltage
    send_word(pspf_pkg::OP_CLEAR, w);
    w.vin_mv = 16'(vin_under_mv - 1);
    send_word(pspf_pkg::OP_EVAL, w);             // input under-voltage
    send_word(pspf_pkg::OP_CLEAR, w);
    w = calm_word(5000);
    w.vin_mv            = 16'd0;                 // absent input never counts as under-voltage
    w.temp_c            = 9'(temp_lim_c - 1);
    w.phase0_current_ma = 18'(phase_lim_ma);
    send_word(pspf_pkg::OP_EVAL, w);
    w.temp_c = 9'(temp_lim_c);
    send_word(pspf_pkg::OP_EVAL, w);             // over-temperature at the limit
    send_word(pspf_pkg::OP_CLEAR, w);
    w = calm_word(5000);
    w.phase3_current_ma = 18'(phase_lim_ma + 1);
    send_word(pspf_pkg::OP_EVAL, w);             // last phase over its limit
    send_word(pspf_pkg::OP_CLEAR, w);
    w = calm_word(5000);
    w.iout_ma    = 19'(out_over_ma + 1);
    w.elapsed_us = 16'(pspf_pkg::OCP_HOLD_US - 1);
    send_word(pspf_pkg::OP_EVAL, w);             // timer one short of the hold time
    w.elapsed_us = 16'd1;
    w.vout_mv    = 16'(ovp_mv);
    send_word(pspf_pkg::OP_EVAL, w);             // hold reached: overrides over-voltage
    send_word(pspf_pkg::OP_CLEAR, w);
    send_word(pspf_pkg::OP_BRAKE, calm_word(5000));
    send_word(pspf_pkg::OP_EVAL, calm_word(5000)); // brake latches on the next evaluation
    send_word(pspf_pkg::OP_CLEAR, w);
    w = '0;
    w.temp_c            = 9'h100;
    w.iout_ma           = 19'h40000;
    w.phase0_current_ma = 18'h20000;
    w.phase1_current_ma = 18'h20000;
    w.phase2_current_ma = 18'h20000;
    w.phase3_current_ma = 18'h20000;
    send_word(pspf_pkg::OP_EVAL, w);             // every field at its minimum
    w = calm_word(pspf_pkg::VOUT_NOMINAL_MV);
    w.iout_ma    = 19'h3FFFF;
    w.elapsed_us = 16'hFFFF;
    send_word(pspf_pkg::OP_EVAL, w);             // timer saturates in one step
    send_word(pspf_pkg::OP_CLEAR, w);

    // Random phases, each under its own limit set and idle pattern.
    for (int ph = 0; ph < 6; ph++) begin
      settle();
      send_gap_pct   = (ph < 2) ? 11 : (ph < 4) ? 57 : 0;
      recv_stall_pct = (ph < 2) ? 57 : (ph < 4) ? 11 : 0;
      case (ph)
        1: begin
          lims[pspf_pkg::REG_OVP]        = pick(1000, 65535);
          lims[pspf_pkg::REG_VIN_OVER]   = pick(0, 65535);
          lims[pspf_pkg::REG_VIN_UNDER]  = pick(0, 65535);
          lims[pspf_pkg::REG_OVER_TEMP]  = pick(-40, 200);
          lims[pspf_pkg::REG_SHORT_VOUT] = pick(0, 65535);
          lims[pspf_pkg::REG_SHORT_IOUT] = pick(0, 262143);
          lims[pspf_pkg::REG_PHASE_OVER] = pick(0, 131071);
          lims[pspf_pkg::REG_OUT_OVER]   = pick(0, 262143);
        end
        2: begin
          lims[pspf_pkg::REG_OVP]        = 0;
          lims[pspf_pkg::REG_VIN_OVER]   = 0;
          lims[pspf_pkg::REG_VIN_UNDER]  = 0;
          lims[pspf_pkg::REG_OVER_TEMP]  = -40;
          lims[pspf_pkg::REG_SHORT_VOUT] = 0;
          lims[pspf_pkg::REG_SHORT_IOUT] = 0;
          lims[pspf_pkg::REG_PHASE_OVER] = 0;
          lims[pspf_pkg::REG_OUT_OVER]   = 0;
        end
        3: begin
          lims[pspf_pkg::REG_OVP]        = 65535;
          lims[pspf_pkg::REG_VIN_OVER]   = 65535;
          lims[pspf_pkg::REG_VIN_UNDER]  = 65535;
          lims[pspf_pkg::REG_OVER_TEMP]  = 200;
          lims[pspf_pkg::REG_SHORT_VOUT] = 65535;
          lims[pspf_pkg::REG_SHORT_IOUT] = 262143;
          lims[pspf_pkg::REG_PHASE_OVER] = 131071;
          lims[pspf_pkg::REG_OUT_OVER]   = 262143;
        end
        4: begin
          // near a real operating point, so the sequence reaches run often
          lims[pspf_pkg::REG_OVP]        = pick(12500, 16000);
          lims[pspf_pkg::REG_VIN_OVER]   = pick(30000, 65535);
          lims[pspf_pkg::REG_VIN_UNDER]  = pick(1, 20000);
          lims[pspf_pkg::REG_OVER_TEMP]  = pick(60, 150);
          lims[pspf_pkg::REG_SHORT_VOUT] = pick(1000, 6000);
          lims[pspf_pkg::REG_SHORT_IOUT] = pick(100000, 250000);
          lims[pspf_pkg::REG_PHASE_OVER] = pick(20000, 100000);
          lims[pspf_pkg::REG_OUT_OVER]   = pick(100000, 250000);
        end
        default: begin
          lims[pspf_pkg::REG_OVP]        = 13500;
          lims[pspf_pkg::REG_VIN_OVER]   = 60000;
          lims[pspf_pkg::REG_VIN_UNDER]  = 9000;
          lims[pspf_pkg::REG_OVER_TEMP]  = 100;
          lims[pspf_pkg::REG_SHORT_VOUT] = 3000;
          lims[pspf_pkg::REG_SHORT_IOUT] = 220000;
          lims[pspf_pkg::REG_PHASE_OVER] = 60000;
          lims[pspf_pkg::REG_OUT_OVER]   = 210000;
        end
      endcase
      for (int r = 0; r < 8; r++) write_limit(pspf_pkg::CFG_ADDR_W'(r), lims[r]);
      cfg_we <= 1'b0;
      @(negedge clk);
      repeat (PHASE_ITEMS) random_item();
    end

    // Closing words: latch a short circuit, which no clear can release.
    settle();
    short_allowed = 1'b1;
    send_word(pspf_pkg::OP_CLEAR, calm_word(5000));
    w = calm_word(0);
    w.iout_ma    = 19'(short_iout_ma + 10000);
    w.elapsed_us = 16'd0;
    send_word(pspf_pkg::OP_EVAL, w);
    send_word(pspf_pkg::OP_CLEAR, w);            // ignored
    send_word(pspf_pkg::OP_EVAL, calm_word(5000));
    send_word(pspf_pkg::OP_BRAKE, w);
    send_word(pspf_pkg::OP_EVAL, calm_word(5000));
    send_word(OP_SPARE, w);
    repeat (20) random_item();
    settle();

    if (bad_results == 0) begin
      $display("tb_power_stage_fault_protector_core: PASS");
    end else begin
      $display("tb_power_stage_fault_protector_core: FAIL");
    end
    $finish;
  end

endmodule
